// File: rtl/hss_pkg.sv
// Package for the Hermitian symmetric swap block: field widths, request and
// status codes, register indexes and the payload types of the word channels.
// Depends on nothing; imported by hermitian_symmetric_swap and the testbench.
`default_nettype none

package hss_pkg;

   localparam int IDX_W   = 6;   // row, column and swap index fields
   localparam int ORDER_W = 7;   // matrix_order register
   localparam int DATA_W  = 64;  // one IEEE-754 double word
   localparam int CSR_W   = 32;  // configuration data path
   localparam int PADDR_W = 3;   // two registers at byte addresses 0 and 4

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_SWAP  = 2'd2;
   localparam logic [1:0] REQ_NONE  = 2'd3;

   // Result status carried in rsp_tuser.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_ORDER = 2'd2;

   // Register index, taken from paddr bit 2.
   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_ORDER = 1'b1;

   localparam logic               UPPER_RESET = 1'b1;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd64;

   // One complex element: imaginary word above the real word.
   typedef struct packed {
      logic [DATA_W-1:0] im_part;
      logic [DATA_W-1:0] re_part;
   } elem_type;

   // Input word layout, last field in the lowest bits.
   typedef struct packed {
      logic [IDX_W-1:0]  second_index;
      logic [IDX_W-1:0]  first_index;
      logic [DATA_W-1:0] elem_imag;
      logic [DATA_W-1:0] elem_real;
      logic [IDX_W-1:0]  col_index;
      logic [IDX_W-1:0]  row_index;
   } req_data_type;

endpackage

`default_nettype wire

// File: rtl/hermitian_symmetric_swap.sv
// Top level of the Hermitian symmetric swap block: element store, swap
// sequencer, request and result word channels and the APB register port.
// Depends on hss_pkg.
`default_nettype none

// The block keeps one triangle of a Hermitian complex matrix of order up to
// MAX_N in a single-port store of MAX_N*MAX_N entries of 128 bits (imaginary
// double above real double). Each request word writes one element, reads one
// element, or performs a symmetric swap of rows and columns first_index and
// second_index inside the triangle selected by upper_part. Every request word
// yields exactly one result word carrying read data (zero unless a good read)
// and a status. A swap visits at most n element pairs, where n is
// matrix_order saturated to MAX_N, and the single store port must do two
// reads and two writes for each pair. The block accepts one request at a
// time and is not ready while one is in progress, but a finished result
// may wait in the output register while the next request is accepted. The
// store is not cleared at reset: its contents are undefined until written,
// so only elements that were written should be read or swapped. Registers
// may be changed only while the block is idle.
module hermitian_symmetric_swap
   import hss_pkg::*;
#(
   parameter int MAX_N = 64
) (
   input  wire  logic               clock,
   input  wire  logic               reset,
   // Request words.
   input  wire  logic               req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0: row_index, col_index, elem_real, elem_imag,
   // first_index, second_index.
   input  wire  logic [151:0]       req_tdata,
   // Fields from bit 0: req_type.
   input  wire  logic [1:0]         req_tuser,
   // Result words.
   output logic                     rsp_tvalid,
   input  wire  logic               rsp_tready,
   // Fields from bit 0: read_real, read_imag.
   output logic [127:0]             rsp_tdata,
   // Fields from bit 0: status.
   output logic [1:0]               rsp_tuser,
   // Register port.
   input  wire  logic               csr_psel,
   input  wire  logic               csr_penable,
   input  wire  logic               csr_pwrite,
   input  wire  logic [PADDR_W-1:0] csr_paddr,
   input  wire  logic [CSR_W-1:0]   csr_pwdata,
   output logic [CSR_W-1:0]         csr_prdata,
   output logic                     csr_pready
);

   // Counter width holds both n itself and the 7-bit order register.
   localparam int CNT_W  = ($clog2(MAX_N + 1) > ORDER_W) ? $clog2(MAX_N + 1) : ORDER_W;
   localparam int DEPTH  = MAX_N * MAX_N;
   localparam int ADDR_W = $clog2(DEPTH);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ACCESS = 4'd1;
   localparam logic [3:0] ST_SCAN   = 4'd2;
   localparam logic [3:0] ST_RD_B   = 4'd3;
   localparam logic [3:0] ST_WR_A   = 4'd4;
   localparam logic [3:0] ST_WR_B   = 4'd5;
   localparam logic [3:0] ST_WR_C   = 4'd6;
   localparam logic [3:0] ST_DONE   = 4'd7;

   // Swap phases, in the order they are walked.
   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_DIAG   = 3'd1;
   localparam logic [2:0] PH_MID    = 3'd2;
   localparam logic [2:0] PH_CORNER = 3'd3;
   localparam logic [2:0] PH_TRAIL  = 3'd4;

   // Configuration registers.
   logic               upper_ff, upper_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic               csr_we;
   logic [CNT_W-1:0]   n_eff;

   // Sequencer and per-request registers.
   logic [3:0]         state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [1:0]         kind_ff, kind_in;
   logic [1:0]         stat_ff, stat_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   i1_ff, i1_in;
   logic [IDX_W-1:0]   i2_ff, i2_in;
   elem_type           wdata_ff, wdata_in;
   elem_type           hold_ff, hold_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   elem_type           rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_stat_ff, rsp_stat_in;

   // Store port.
   elem_type           mem [DEPTH];
   elem_type           rdata_ff;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;
   logic               mem_re;
   elem_type           mem_wdata;
   elem_type           wsrc;
   logic               wflip;

   req_data_type       req_d;
   logic               req_hs;
   logic [CNT_W-1:0]   row_c, col_c, i1_in_c, i2_in_c;
   logic [CNT_W-1:0]   i1_c, i2_c;
   logic               scan_hit;
   logic               side_b;
   logic               mirror;
   logic [CNT_W-1:0]   r_sel, c_sel, hi_sel, lo_sel;
   logic               conj;

   // ---------------------------------------------------------------------
   // Register port. pready is tied high, so every access completes in its
   // access phase.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      upper_in = upper_ff;
      order_in = order_ff;
      if (csr_we) begin
         if (csr_paddr[2] == REG_UPPER) begin
            upper_in = csr_pwdata[0];
         end else begin
            order_in = csr_pwdata[ORDER_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ORDER) ?
                       CSR_W'(order_ff) : CSR_W'(upper_ff);

   // The order in use never exceeds the store's dimension.
   assign n_eff = (CNT_W'(order_ff) > CNT_W'(MAX_N)) ? CNT_W'(MAX_N) : CNT_W'(order_ff);

   // ---------------------------------------------------------------------
   // Request decode.
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_hs     = req_tvalid & req_tready;
   assign req_d      = req_data_type'(req_tdata);
   assign row_c      = CNT_W'(req_d.row_index);
   assign col_c      = CNT_W'(req_d.col_index);
   assign i1_in_c    = CNT_W'(req_d.first_index);
   assign i2_in_c    = CNT_W'(req_d.second_index);
   assign i1_c       = CNT_W'(i1_ff);
   assign i2_c       = CNT_W'(i2_ff);

   // ---------------------------------------------------------------------
   // Swap walk. Each phase names element pair (a, b) for step k:
   //   leading part   (k,i1)  <-> (k,i2)   for k < i1
   //   diagonal       (i1,i1) <-> (i2,i2)
   //   middle strip   (i1,k)  <-> (k,i2)   for i1 < k < i2, conjugated
   //   corner         (i1,i2) conjugated in place
   //   trailing part  (i1,k)  <-> (i2,k)   for i2 < k < n
   // Coordinates are in upper-triangle terms and mirrored for the lower.
   // ---------------------------------------------------------------------
   always_comb begin
      case (phase_ff)
         PH_LEAD:   scan_hit = (k_ff < i1_c);
         PH_DIAG:   scan_hit = 1'b1;
         PH_MID:    scan_hit = (k_ff < i2_c);
         PH_CORNER: scan_hit = 1'b1;
         PH_TRAIL:  scan_hit = (k_ff < n_eff);
         default:   scan_hit = 1'b0;
      endcase
   end

   assign side_b = (state_ff == ST_RD_B) || (state_ff == ST_WR_B);
   assign conj   = (phase_ff == PH_MID);

   always_comb begin
      r_sel = CNT_W'(row_ff);
      c_sel = CNT_W'(col_ff);
      if (state_ff != ST_ACCESS) begin
         case (phase_ff)
            PH_LEAD: begin
               r_sel = k_ff;
               c_sel = side_b ? i2_c : i1_c;
            end
            PH_DIAG: begin
               r_sel = side_b ? i2_c : i1_c;
               c_sel = side_b ? i2_c : i1_c;
            end
            PH_MID: begin
               r_sel = side_b ? k_ff : i1_c;
               c_sel = side_b ? i2_c : k_ff;
            end
            PH_CORNER: begin
               r_sel = i1_c;
               c_sel = i2_c;
            end
            PH_TRAIL: begin
               r_sel = side_b ? i2_c : i1_c;
               c_sel = k_ff;
            end
            default: begin
               r_sel = i1_c;
               c_sel = i1_c;
            end
         endcase
      end
   end

   // Plain element accesses always use row-major addressing; only the swap
   // walk mirrors into the stored triangle.
   assign mirror   = !upper_ff && (state_ff != ST_ACCESS);
   assign hi_sel   = mirror ? c_sel : r_sel;
   assign lo_sel   = mirror ? r_sel : c_sel;
   assign mem_addr = ADDR_W'(ADDR_W'(hi_sel) * ADDR_W'(MAX_N)) + ADDR_W'(lo_sel);

   // Store port control. The read register only loads on a read, so read
   // data survives the write cycles that follow it.
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      wsrc   = rdata_ff;
      wflip  = 1'b0;
      case (state_ff)
         ST_ACCESS: begin
            mem_we = (kind_ff == REQ_WRITE);
            mem_re = (kind_ff == REQ_READ);
            wsrc   = wdata_ff;
         end
         ST_SCAN: begin
            mem_re = scan_hit;
         end
         ST_RD_B: begin
            mem_re = 1'b1;
         end
         ST_WR_A: begin
            mem_we = 1'b1;
            wflip  = conj;
         end
         ST_WR_B: begin
            mem_we = 1'b1;
            wsrc   = hold_ff;
            wflip  = conj;
         end
         ST_WR_C: begin
            mem_we = 1'b1;
            wflip  = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      mem_wdata                    = wsrc;
      mem_wdata.im_part[DATA_W-1]  = wsrc.im_part[DATA_W-1] ^ wflip;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      kind_in      = kind_ff;
      stat_in      = stat_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      wdata_in     = wdata_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               kind_in           = req_tuser;
               row_in            = req_d.row_index;
               col_in            = req_d.col_index;
               i1_in             = req_d.first_index;
               i2_in             = req_d.second_index;
               wdata_in.re_part  = req_d.elem_real;
               wdata_in.im_part  = req_d.elem_imag;
               stat_in           = STAT_OK;
               phase_in          = PH_LEAD;
               k_in              = '0;
               state_in          = ST_DONE;
               case (req_tuser)
                  REQ_WRITE, REQ_READ: begin
                     if (row_c >= n_eff || col_c >= n_eff) begin
                        stat_in = STAT_RANGE;
                     end else begin
                        state_in = ST_ACCESS;
                     end
                  end
                  REQ_SWAP: begin
                     if (i1_in_c >= n_eff || i2_in_c >= n_eff) begin
                        stat_in = STAT_RANGE;
                     end else if (i1_in_c > i2_in_c) begin
                        stat_in = STAT_ORDER;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_NONE: begin
                     stat_in = STAT_OK;
                  end
                  default: begin
                     stat_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = (phase_ff == PH_CORNER) ? ST_WR_C : ST_RD_B;
            end else begin
               case (phase_ff)
                  PH_LEAD: phase_in = PH_DIAG;
                  PH_MID:  phase_in = PH_CORNER;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_B: begin
            hold_in  = rdata_ff;
            state_in = ST_WR_A;
         end
         ST_WR_A: begin
            state_in = ST_WR_B;
         end
         ST_WR_B, ST_WR_C: begin
            state_in = ST_SCAN;
            case (phase_ff)
               PH_DIAG: begin
                  phase_in = PH_MID;
                  k_in     = i1_c + CNT_W'(1);
               end
               PH_CORNER: begin
                  phase_in = PH_TRAIL;
                  k_in     = i2_c + CNT_W'(1);
               end
               default: begin
                  k_in = k_ff + CNT_W'(1);
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_data_in  = (kind_ff == REQ_READ && stat_ff == STAT_OK) ? rdata_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LEAD;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         upper_ff     <= UPPER_RESET;
         order_ff     <= ORDER_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         upper_ff     <= upper_in;
         order_ff     <= order_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      stat_ff     <= stat_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      wdata_ff    <= wdata_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The store is only written in the access and write steps.
   a_write_steps: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_ACCESS || state_ff == ST_WR_A ||
                  state_ff == ST_WR_B || state_ff == ST_WR_C))
      else $error("store written outside an access or write step");

   // The walk counter never runs past the order during a swap.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_RD_B || state_ff == ST_WR_A ||
       state_ff == ST_WR_B || state_ff == ST_WR_C) |-> (k_ff <= n_eff))
      else $error("swap walk counter beyond matrix order");

   // A failed request never returns data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata == '0))
      else $error("result with error status carries data");

   // An accepted request always leaves the idle state.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_hs |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start");

   // The second write of a pair always follows the first.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_A) |=> (state_ff == ST_WR_B))
      else $error("exchange pair broken");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for hermitian_symmetric_swap: request and result word
// streams, APB register writes with read-back, and a predictor of the element store.
// Depends on hss_pkg and the hermitian_symmetric_swap top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hss_pkg::*;

   localparam int          MAX_N       = 64;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          CHUNKS      = 10;
   localparam int          CHUNK_WORDS = 75;
   // Wait longer than a full-order swap at the end so that a stray extra
   // result word would still be seen.
   localparam int          TAIL_CYCLES = 300;

   // One request word as the sender drives it: the kind travels on tuser.
   typedef struct packed {
      logic [1:0]   kind;
      req_data_type data;
   } req_word_t;

   // One result word: read data and status.
   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] im_word;
      logic [DATA_W-1:0] re_word;
   } result_t;

   // A row of the directed stimulus: either a register write or a request
   // word, the latter optionally with its result written out by hand.
   typedef struct {
      bit                 is_cfg;
      logic               cfg_reg;
      logic [CSR_W-1:0]   cfg_value;
      req_word_t          word;
      bit                 typed;
      result_t            want;
   } dir_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [151:0]       req_tdata = '0;
   logic [1:0]         req_tuser = REQ_NONE;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [127:0]       rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [CSR_W-1:0]   csr_pwdata = '0;
   logic [CSR_W-1:0]   csr_prdata;
   logic               csr_pready;

   // Predictor state: the element store as the block should hold it, plus
   // the two configuration registers.
   elem_type           herm_store [MAX_N*MAX_N];
   logic               model_upper;
   logic [ORDER_W-1:0] model_order;

   result_t     pending_results [$];
   dir_row_t    directed_rows [$];
   bit          idle_on = 1'b0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned n_words = 0;
   int unsigned n_checked = 0;
   int unsigned n_swaps = 0;
   int unsigned n_settings = 0;

   hermitian_symmetric_swap #(.MAX_N(MAX_N)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d result words outstanding",
                  cycle_count, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // The order register saturates at the store size.
   function automatic int unsigned eff_order();
      return (model_order > MAX_N) ? MAX_N : model_order;
   endfunction

   // Store address of element (r,c) named in upper-triangle terms. With the
   // lower triangle stored, the same element lives at the mirrored place.
   function automatic int unsigned tri_addr(input int unsigned r, input int unsigned c);
      return model_upper ? r * MAX_N + c : c * MAX_N + r;
   endfunction

   // Exchange two entries, optionally conjugating both on the way.
   function automatic void trade(input int unsigned a, input int unsigned b,
                                 input bit conj);
      elem_type held;
      held          = herm_store[a];
      herm_store[a] = herm_store[b];
      herm_store[b] = held;
      if (conj) begin
         herm_store[a].im_part[DATA_W-1] = ~herm_store[a].im_part[DATA_W-1];
         herm_store[b].im_part[DATA_W-1] = ~herm_store[b].im_part[DATA_W-1];
      end
   endfunction

   // Symmetric exchange of rows and columns i1 <= i2 within the stored
   // triangle. Column i1 above the diagonal trades with column i2, the
   // diagonals trade, the strip between them moves across the diagonal and
   // is conjugated on the way, the corner is conjugated in place, and row
   // i1 past i2 trades with row i2. With i1 == i2 only the conjugation of
   // the diagonal entry has any effect.
   function automatic void swap_rows_cols(input int unsigned i1, input int unsigned i2,
                                          input int unsigned n);
      int unsigned corner;
      for (int unsigned k = 0; k < i1; k++)
         trade(tri_addr(k, i1), tri_addr(k, i2), 1'b0);
      trade(tri_addr(i1, i1), tri_addr(i2, i2), 1'b0);
      for (int unsigned k = i1 + 1; k < i2; k++)
         trade(tri_addr(i1, k), tri_addr(k, i2), 1'b1);
      corner = tri_addr(i1, i2);
      herm_store[corner].im_part[DATA_W-1] = ~herm_store[corner].im_part[DATA_W-1];
      for (int unsigned k = i2 + 1; k < n; k++)
         trade(tri_addr(i1, k), tri_addr(i2, k), 1'b0);
   endfunction

   // Apply one accepted request word to the store and return its result.
   // Reads and writes address the full square regardless of the triangle.
   function automatic result_t apply_request(input req_word_t w);
      result_t     res;
      int unsigned n;
      int unsigned addr;
      res  = '0;
      n    = eff_order();
      addr = w.data.row_index * MAX_N + w.data.col_index;
      case (w.kind)
         REQ_WRITE, REQ_READ: begin
            if (w.data.row_index >= n || w.data.col_index >= n) begin
               res.status = STAT_RANGE;
            end else if (w.kind == REQ_WRITE) begin
               herm_store[addr].re_part = w.data.elem_real;
               herm_store[addr].im_part = w.data.elem_imag;
            end else begin
               res.re_word = herm_store[addr].re_part;
               res.im_word = herm_store[addr].im_part;
            end
         end
         REQ_SWAP: begin
            if (w.data.first_index >= n || w.data.second_index >= n) begin
               res.status = STAT_RANGE;
            end else if (w.data.first_index > w.data.second_index) begin
               res.status = STAT_ORDER;
            end else begin
               swap_rows_cols(w.data.first_index, w.data.second_index, n);
               n_swaps++;
            end
         end
         default: ;  // the unused kind leaves everything alone
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_word_t make_word(input logic [1:0] kind,
                                           input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c,
                                           input logic [DATA_W-1:0] re,
                                           input logic [DATA_W-1:0] im,
                                           input logic [IDX_W-1:0] i1,
                                           input logic [IDX_W-1:0] i2);
      req_word_t w;
      w.kind              = kind;
      w.data.row_index    = r;
      w.data.col_index    = c;
      w.data.elem_real    = re;
      w.data.elem_imag    = im;
      w.data.first_index  = i1;
      w.data.second_index = i2;
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] random_double_bits();
      return {$urandom, $urandom};
   endfunction

   // Mostly in range for the current order, now and then anywhere.
   function automatic logic [IDX_W-1:0] pick_index();
      int unsigned n;
      n = eff_order();
      if (n != 0 && $urandom_range(0, 9) != 0)
         return $urandom_range(0, n - 1);
      return $urandom_range(0, MAX_N - 1);
   endfunction

   // Random request word. Most swaps are well formed so that they reach the
   // full exchange; the rest are left as drawn and may be misordered.
   function automatic req_word_t random_word();
      req_word_t         w;
      int unsigned       pick;
      logic [1:0]        kind;
      logic [IDX_W-1:0]  hold;
      pick = $urandom_range(0, 99);
      if (pick < 35)      kind = REQ_WRITE;
      else if (pick < 65) kind = REQ_READ;
      else if (pick < 95) kind = REQ_SWAP;
      else                kind = REQ_NONE;
      w = make_word(kind, pick_index(), pick_index(), random_double_bits(),
                    random_double_bits(), pick_index(), pick_index());
      if (kind == REQ_SWAP && $urandom_range(0, 9) != 0 &&
          w.data.first_index > w.data.second_index) begin
         hold                = w.data.first_index;
         w.data.first_index  = w.data.second_index;
         w.data.second_index = hold;
      end
      return w;
   endfunction

   function automatic result_t mk_result(input logic [DATA_W-1:0] re,
                                         input logic [DATA_W-1:0] im,
                                         input logic [1:0] st);
      result_t res;
      res.re_word = re;
      res.im_word = im;
      res.status  = st;
      return res;
   endfunction

   function automatic dir_row_t req_row(input req_word_t w);
      dir_row_t row;
      row.is_cfg    = 1'b0;
      row.cfg_reg   = REG_UPPER;
      row.cfg_value = '0;
      row.word      = w;
      row.typed     = 1'b0;
      row.want      = '0;
      return row;
   endfunction

   function automatic dir_row_t checked_row(input req_word_t w, input result_t want);
      dir_row_t row;
      row       = req_row(w);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic dir_row_t cfg_row(input logic sel, input logic [CSR_W-1:0] value);
      dir_row_t row;
      row           = req_row('0);
      row.is_cfg    = 1'b1;
      row.cfg_reg   = sel;
      row.cfg_value = value;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers. Every task is entered right after a rising edge and drives
   // with nonblocking assignments, so the block sees stable inputs.
   // ---------------------------------------------------------------------

   // Offer one request word, with an optional idle gap first. When it is
   // accepted, the predictor runs and the expected result is queued, taken
   // from the table instead when the row spells it out.
   task automatic push_request(input req_word_t w, input bit typed, input result_t want);
      result_t predicted;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.kind;
      req_tdata  <= w.data;
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(w);
      pending_results.push_back(typed ? want : predicted);
      n_words++;
   endtask

   // Stop sending and wait until every expected result word has arrived.
   // Always waits on the clock before returning, so the next driver starts fresh.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // APB write followed by a read-back of the same register. Only the low
   // bits are kept by the block; the rest of the write data is noise.
   task automatic write_register(input logic sel, input logic [CSR_W-1:0] value);
      logic [CSR_W-1:0] want;
      want = (sel == REG_UPPER) ? (value & 32'h1) : (value & 32'h7F);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == REG_UPPER) model_upper = value[0];
      else                  model_order = value[ORDER_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         flag_mismatch($sformatf("register %0d read back %h, want %h",
                                 sel, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   // Receiver stalls come in bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left  <= stall_left - 1;
         rsp_tready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left  <= $urandom_range(0, 18);
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready  <= 1'b1;
      end
   end

   // Result checker: every accepted result word is matched against the
   // oldest expectation, field by field.
   always @(posedge clock) begin
      result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result word with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_tdata[63:0] !== want.re_word)
               flag_mismatch($sformatf("read_real %h, want %h",
                                       rsp_tdata[63:0], want.re_word));
            if (rsp_tdata[127:64] !== want.im_word)
               flag_mismatch($sformatf("read_imag %h, want %h",
                                       rsp_tdata[127:64], want.im_word));
            if (rsp_tuser !== want.status)
               flag_mismatch($sformatf("result code %0d, want %0d",
                                       rsp_tuser, want.status));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      model_upper = UPPER_RESET;
      model_order = ORDER_RESET;

      // Directed rows. Results are spelled out where they follow directly
      // from the row itself: writes, read-back of a fresh write, the unused
      // kind, and rejections. Swaps and what they move are predicted.
      directed_rows.push_back(checked_row(make_word(REQ_WRITE, 0, 0, '0, '0, 0, 0),
                                          mk_result('0, '0, STAT_OK)));
      directed_rows.push_back(checked_row(make_word(REQ_READ, 0, 0, '0, '0, 0, 0),
                                          mk_result('0, '0, STAT_OK)));
      directed_rows.push_back(checked_row(make_word(REQ_WRITE, 63, 63, '1, '1, 0, 0),
                                          mk_result('0, '0, STAT_OK)));
      directed_rows.push_back(checked_row(make_word(REQ_READ, 63, 63, '0, '0, 63, 63),
                                          mk_result('1, '1, STAT_OK)));
      directed_rows.push_back(checked_row(make_word(REQ_WRITE, 0, 63,
                                                    64'h8000_0000_0000_0000,
                                                    64'h7FF0_0000_0000_0000, 0, 0),
                                          mk_result('0, '0, STAT_OK)));
      directed_rows.push_back(req_row(make_word(REQ_READ, 63, 0, '0, '0, 0, 0)));
      directed_rows.push_back(checked_row(make_word(REQ_NONE, 63, 63, '1, '1, 63, 63),
                                          mk_result('0, '0, STAT_OK)));
      // Misordered swap indices are rejected.
      directed_rows.push_back(checked_row(make_word(REQ_SWAP, 0, 0, '0, '0, 5, 3),
                                          mk_result('0, '0, STAT_ORDER)));
      // Widest swap, an equal-index swap, and the last two rows.
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 0, 63)));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 7, 7)));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 62, 63)));
      directed_rows.push_back(req_row(make_word(REQ_READ, 0, 63, '0, '0, 0, 0)));
      // Smaller order: anything at or past it is out of range.
      directed_rows.push_back(cfg_row(REG_ORDER, 32'd10));
      directed_rows.push_back(checked_row(make_word(REQ_WRITE, 10, 0, '1, '1, 0, 0),
                                          mk_result('0, '0, STAT_RANGE)));
      directed_rows.push_back(checked_row(make_word(REQ_READ, 0, 10, '0, '0, 0, 0),
                                          mk_result('0, '0, STAT_RANGE)));
      directed_rows.push_back(checked_row(make_word(REQ_SWAP, 0, 0, '0, '0, 3, 10),
                                          mk_result('0, '0, STAT_RANGE)));
      directed_rows.push_back(checked_row(make_word(REQ_SWAP, 0, 0, '0, '0, 9, 3),
                                          mk_result('0, '0, STAT_ORDER)));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 2, 9)));
      // Lower triangle.
      directed_rows.push_back(cfg_row(REG_UPPER, 32'd0));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 0, 9)));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 4, 4)));
      directed_rows.push_back(req_row(make_word(REQ_READ, 9, 0, '0, '0, 0, 0)));
      // Order zero rejects everything.
      directed_rows.push_back(cfg_row(REG_ORDER, 32'd0));
      directed_rows.push_back(checked_row(make_word(REQ_READ, 0, 0, '0, '0, 0, 0),
                                          mk_result('0, '0, STAT_RANGE)));
      // Order above the store size saturates to the full matrix.
      directed_rows.push_back(cfg_row(REG_ORDER, 32'd127));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 0, 63)));
      // Order one: a single element.
      directed_rows.push_back(cfg_row(REG_ORDER, 32'd1));
      directed_rows.push_back(req_row(make_word(REQ_SWAP, 0, 0, '0, '0, 0, 0)));
      directed_rows.push_back(checked_row(make_word(REQ_WRITE, 1, 0, '0, '0, 0, 0),
                                          mk_result('0, '0, STAT_RANGE)));
      directed_rows.push_back(cfg_row(REG_UPPER, 32'd1));
      directed_rows.push_back(cfg_row(REG_ORDER, 32'd64));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The store is undefined after reset, and swaps move entries around
      // the whole triangle, so every entry is written once before anything
      // reads or swaps. Idling is on here, so gaps hit the write path.
      idle_on = 1'b1;
      for (int unsigned r = 0; r < MAX_N; r++)
         for (int unsigned c = 0; c < MAX_N; c++)
            push_request(make_word(REQ_WRITE, r, c, random_double_bits(),
                                   random_double_bits(), $urandom_range(0, 63),
                                   $urandom_range(0, 63)), 1'b0, '0);
      settle();

      // Registers change only with nothing in flight.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            settle();
            write_register(directed_rows[i].cfg_reg, directed_rows[i].cfg_value);
         end else begin
            push_request(directed_rows[i].word, directed_rows[i].typed,
                         directed_rows[i].want);
         end
      end

      // Random part in chunks. Before each chunk the sender waits for every
      // outstanding result, then both registers get a new setting with
      // noise in the unused write bits. The last chunks run without idling.
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         logic [ORDER_W-1:0] ord;
         settle();
         case ($urandom_range(0, 6))
            0:       ord = 7'd0;
            1:       ord = 7'd1;
            2:       ord = 7'd2;
            3:       ord = 7'd64;
            4:       ord = 7'd127;
            5:       ord = $urandom_range(3, 63);
            default: ord = $urandom_range(65, 126);
         endcase
         write_register(REG_UPPER, {$urandom} & ~32'h1 | $urandom_range(0, 1));
         write_register(REG_ORDER, {$urandom} & ~32'h7F | ord);
         idle_on = (chunk < CHUNKS - 2) && ($urandom_range(0, 3) != 0);
         repeat (CHUNK_WORDS) push_request(random_word(), 1'b0, '0);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d request words, %0d good swaps, %0d register settings",
               n_words, n_swaps, n_settings);
      $display("checked %0d result words, %0d mismatches", n_checked, error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
